FILE: design/aem_pkg.sv
// Shared constants and types for the echo mixer.
package aem_pkg;

  localparam int MAX_DELAY = 8192;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 14;
  localparam int DIVISOR_W = 15;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W    = $clog2(SAMPLE_W);

  localparam logic [DELAY_W-1:0]   DELAY_RST   = DELAY_W'(8000);
  localparam logic [DIVISOR_W-1:0] DIVISOR_RST = DIVISOR_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_DELAY   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_DIVISOR = CFG_IDX_W'(1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input beat taken: latch sample, compute read address
    logic rd;        // read delayed sample from history
    logic load;      // load divider, write history, advance pointer
    logic step;      // one divider iteration
    logic load_out;  // capture mixed sample into output register
  } aem_cmd_t;

endpackage

FILE: design/aem_ctrl.sv
// Controller state machine for the echo mixer.
module aem_ctrl import aem_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output aem_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t             state_r;
  logic [STEP_W-1:0]  step_r;
  logic               out_valid_r;
  logic               fin_go;

  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == ST_IDLE) && in_valid;
    cmd.rd       = (state_r == ST_READ);
    cmd.load     = (state_r == ST_LOAD);
    cmd.step     = (state_r == ST_DIV);
    cmd.load_out = fin_go;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken; a fresh load takes priority
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(SAMPLE_W - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/aem_dp.sv
// Datapath for the echo mixer: history memory, pointers, divider, mixer.
module aem_dp import aem_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  aem_cmd_t                   cmd,
  input  logic                       in_kind,
  input  logic                       in_first,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       cfg_valid,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [DIVISOR_W-1:0]       cfg_data,
  output logic signed [SAMPLE_W-1:0] out_sample
);

  logic [SAMPLE_W-1:0]  hist_mem [MAX_DELAY];

  logic [DELAY_W-1:0]   delay_r;
  logic [DIVISOR_W-1:0] divisor_r;
  logic [ADDR_W-1:0]    wp_r;
  logic [CNT_W-1:0]     fill_r;
  logic [ADDR_W-1:0]    rd_addr_r;
  logic                 echo_en_r;
  logic [SAMPLE_W-1:0]  x_r;
  logic [SAMPLE_W-1:0]  rd_data_r;
  logic                 neg_r;
  logic [SAMPLE_W-1:0]  q_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic [DELAY_W-1:0]   delay_eff;
  logic [DIVISOR_W-1:0] divisor_eff;
  logic [CNT_W-1:0]     fill_eff;
  logic [SAMPLE_W-1:0]  trial;
  logic                 fits;
  logic [SAMPLE_W-1:0]  echo_v;

  always_comb begin
    if (delay_r == '0) begin
      delay_eff = DELAY_W'(1);
    end else if (delay_r > DELAY_W'(MAX_DELAY)) begin
      delay_eff = DELAY_W'(MAX_DELAY);
    end else begin
      delay_eff = delay_r;
    end
    divisor_eff = (divisor_r == '0) ? DIVISOR_W'(1) : divisor_r;
    fill_eff    = in_first ? '0 : fill_r;
    trial       = {rem_r, q_r[SAMPLE_W-1]};
    fits        = (trial >= {1'b0, divisor_eff});
    echo_v      = neg_r ? (~q_r + 1'b1) : q_r;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r   <= DELAY_RST;
      divisor_r <= DIVISOR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ECHO_DELAY:   delay_r   <= cfg_data[DELAY_W-1:0];
        CFG_ECHO_DIVISOR: divisor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (cmd.accept) begin
        fill_r <= (fill_eff < CNT_W'(MAX_DELAY)) ? fill_eff + 1'b1 : fill_eff;
      end
      if (cmd.load) begin
        wp_r <= wp_r + 1'b1;
      end
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r       <= in_kind ? '0 : in_sample;
      echo_en_r <= ({1'b0, fill_eff} >= {1'b0, delay_eff});
      rd_addr_r <= wp_r - delay_eff[ADDR_W-1:0];
    end
  end

  // History memory
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= hist_mem[rd_addr_r];
    end
    if (cmd.load) begin
      hist_mem[wp_r] <= x_r;
    end
  end

  // Restoring divider on the magnitude, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= echo_en_r && rd_data_r[SAMPLE_W-1];
      rem_r <= '0;
      if (!echo_en_r) begin
        q_r <= '0;
      end else if (rd_data_r[SAMPLE_W-1]) begin
        q_r <= ~rd_data_r + 1'b1;
      end else begin
        q_r <= rd_data_r;
      end
    end else if (cmd.step) begin
      rem_r <= fits ? DIVISOR_W'(trial - {1'b0, divisor_eff}) : trial[DIVISOR_W-1:0];
      q_r   <= {q_r[SAMPLE_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= $signed(x_r + echo_v);
    end
  end

  assign out_sample = out_sample_r;

endmodule

FILE: design/audio_echo_mixer.sv
// Top level of the delay-line echo mixer for 16-bit PCM audio.
//
// Each input beat (in_kind, in_first, in_sample) yields one output beat
// out_sample = x[n] + x[n-delay]/divisor, quotient truncated toward zero
// and the sum wrapped to 16 bits. A flush tick (in_kind = 1) counts as a
// zero sample; send echo_delay flush ticks after the last sample to drain
// the echo tail. in_first restarts the fill count, so the echo stays zero
// until echo_delay items of the new stream have gone by.
// Config: cfg_index 0 = echo_delay, 1 = echo_divisor, via cfg_valid/cfg_data
// (cfg_ready always high); write only while idle, the block does not check.
// Sequence: an accepted item has its delayed sample read from history, then
// loads the divider while it is written to history, runs the 16-step
// bit-serial divider and is loaded into the output register; no new item
// is accepted before that load. The next item is accepted while a result
// waits in the output register; if the receiver stalls, the finished
// result of that next item holds inside until the register frees.
// Reset: echo_delay = 8000, echo_divisor = 4, pointer and fill count zero.
// History memory needs no clearing pass; reads of unfilled slots go unused.
module audio_echo_mixer import aem_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic                        in_first,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_sample,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DIVISOR_W-1:0]        cfg_data
);

  aem_cmd_t cmd;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  aem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  aem_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_kind    (in_kind),
    .in_first   (in_first),
    .in_sample  (in_sample),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_sample (out_sample)
  );

endmodule
